[rtl/bsrp_pkg.sv]
// Shared types and constants for the band select relay pulser.
// No dependencies; used by every module in rtl/.
`default_nettype none

package bsrp_pkg;

  // Debounce run length: released ticks that must follow one pressed tick
  localparam int unsigned RELEASE_RUN_DEF = 12;

  localparam int unsigned PULSE_W = 8;
  localparam logic [PULSE_W-1:0] PULSE_TICKS_RST = 8'd3;

  localparam int unsigned BAND_W = 2;

  // Band codes; BAND_NONE differs from every real band and forces the first update
  localparam logic [BAND_W-1:0] BAND_40M  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_20M  = 2'd1;
  localparam logic [BAND_W-1:0] BAND_15M  = 2'd2;
  localparam logic [BAND_W-1:0] BAND_NONE = 2'd3;

  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef struct packed {
    logic [BAND_W-1:0] band_index;
    logic              select_20m;
    logic              select_15m;
    logic              relay12_set;
    logic              relay12_reset;
    logic              relay34_set;
    logic              relay34_reset;
    logic              cal_line;
  } result_t;

endpackage

`default_nettype wire

[rtl/bsrp_core.sv]
// Per-tick state update: debounce history, band counter, select lines,
// relay pulse counters and calibration toggle. Depends on bsrp_pkg.
`default_nettype none

module bsrp_core #(
  parameter int unsigned RELEASE_RUN = bsrp_pkg::RELEASE_RUN_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         tick_acc,
  input  wire logic                         button_level,
  input  wire logic                         cfg_wr_en,
  input  wire logic [bsrp_pkg::PULSE_W-1:0] cfg_wr_data,
  output bsrp_pkg::result_t                 result
);

  localparam int unsigned HIST_W = RELEASE_RUN + 1;
  // one pressed sample in the oldest slot, all later samples released
  localparam logic [HIST_W-1:0] HIST_MATCH = {1'b1, {RELEASE_RUN{1'b0}}};

  logic [HIST_W-1:0]                 hist_r, hist_nxt;
  logic [bsrp_pkg::BAND_W-1:0]       band_now_r, band_now_nxt;
  logic [bsrp_pkg::BAND_W-1:0]       band_app_r, band_app_nxt;
  logic [1:0]                        sel_r, sel_nxt;
  logic [bsrp_pkg::PULSE_W-1:0]      r12s_r, r12s_nxt, r12r_r, r12r_nxt;
  logic [bsrp_pkg::PULSE_W-1:0]      r34s_r, r34s_nxt, r34r_r, r34r_nxt;
  logic                              cal_r, cal_nxt;
  logic [bsrp_pkg::PULSE_W-1:0]      pulse_ticks_r;

  function automatic logic [bsrp_pkg::PULSE_W-1:0] count_down(
    input logic [bsrp_pkg::PULSE_W-1:0] c
  );
    return (c != '0) ? c - 1'b1 : '0;
  endfunction

  always_comb begin
    hist_nxt     = {hist_r[HIST_W-2:0], ~button_level};
    band_now_nxt = band_now_r;
    if (hist_nxt == HIST_MATCH) begin
      band_now_nxt = (band_now_r == bsrp_pkg::BAND_15M) ? bsrp_pkg::BAND_40M
                                                        : band_now_r + 1'b1;
    end
    cal_nxt      = ~cal_r;
    r12s_nxt     = count_down(r12s_r);
    r12r_nxt     = count_down(r12r_r);
    r34s_nxt     = count_down(r34s_r);
    r34r_nxt     = count_down(r34r_r);
    sel_nxt      = sel_r;
    band_app_nxt = band_app_r;
    if (band_now_nxt != band_app_r) begin
      band_app_nxt = band_now_nxt;
      case (band_now_nxt)
        bsrp_pkg::BAND_40M: begin
          sel_nxt  = 2'b00;
          r12r_nxt = pulse_ticks_r;
          r34r_nxt = pulse_ticks_r;
        end
        bsrp_pkg::BAND_20M: begin
          sel_nxt  = 2'b01;
          r12r_nxt = pulse_ticks_r;
          r34s_nxt = pulse_ticks_r;
        end
        default: begin
          sel_nxt  = 2'b10;
          r12s_nxt = pulse_ticks_r;
        end
      endcase
    end
  end

  always_comb begin
    result.band_index    = band_now_nxt;
    result.select_20m    = sel_nxt[0];
    result.select_15m    = sel_nxt[1];
    result.relay12_set   = (r12s_nxt != '0);
    result.relay12_reset = (r12r_nxt != '0);
    result.relay34_set   = (r34s_nxt != '0);
    result.relay34_reset = (r34r_nxt != '0);
    result.cal_line      = cal_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r     <= '0;
      band_now_r <= bsrp_pkg::BAND_40M;
      band_app_r <= bsrp_pkg::BAND_NONE;
      sel_r      <= '0;
      r12s_r     <= '0;
      r12r_r     <= '0;
      r34s_r     <= '0;
      r34r_r     <= '0;
      cal_r      <= 1'b0;
    end else if (tick_acc) begin
      hist_r     <= hist_nxt;
      band_now_r <= band_now_nxt;
      band_app_r <= band_app_nxt;
      sel_r      <= sel_nxt;
      r12s_r     <= r12s_nxt;
      r12r_r     <= r12r_nxt;
      r34s_r     <= r34s_nxt;
      r34r_r     <= r34r_nxt;
      cal_r      <= cal_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_ticks_r <= bsrp_pkg::PULSE_TICKS_RST;
    end else if (cfg_wr_en) begin
      pulse_ticks_r <= cfg_wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/bsrp_outbuf.sv]
// Result register with a one-entry skid slot, so a new item is taken
// while a finished result waits. Depends on bsrp_pkg.
`default_nettype none

module bsrp_outbuf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bsrp_pkg::result_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bsrp_pkg::result_t      out_data
);

  logic              out_valid_r, out_valid_nxt;
  logic              skid_valid_r, skid_valid_nxt;
  bsrp_pkg::result_t out_data_r, out_data_nxt;
  bsrp_pkg::result_t skid_data_r, skid_data_nxt;
  logic              in_acc;

  assign in_ready = ~skid_valid_r;
  assign in_acc   = in_valid & in_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_ready) begin
      // output slot free or draining: refill from skid first, else from input
      out_valid_nxt  = skid_valid_r | in_acc;
      out_data_nxt   = skid_valid_r ? skid_data_r : in_data;
      skid_valid_nxt = 1'b0;
    end else if (in_acc) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/band_select_relay_pulser_top.sv]
// Top level of the band select relay pulser: stream ports, config port.
// Depends on bsrp_pkg, bsrp_core and bsrp_outbuf.
//
// Usage:
//   in_*  : one item per millisecond tick; in_tdata[0] is the sampled band
//           button pin (0 = pressed). Other tdata bits are ignored.
//   out_* : one result item per tick: current band, the two band-select
//           lines, the four latching-relay pulse lines and the calibration
//           toggle, all as they stand after that tick.
//   cfg_* : cfg_wr_en writes cfg_wr_data into pulse_ticks (ticks each relay
//           pulse stays high, reset 3); write only while the block is idle.
// Output: an item's result is registered in the output buffer before it
//   reaches out_tdata. Throughput: one item per cycle while out_tready is
//   high; the tick state updates on each accepted item, and the result
//   register plus skid slot let input continue while a result waits.
// Reset (rst_n low, synchronous): band 0 with band-applied marked unknown,
//   so the first tick after reset drives the band-0 select lines and starts
//   both reset pulses. Output buffer empties.
// Stall: when out_tready is low, one further item is held in the skid slot,
//   then in_tready drops until the receiver takes a result.
`default_nettype none

module band_select_relay_pulser_top #(
  parameter int unsigned RELEASE_RUN = bsrp_pkg::RELEASE_RUN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [0] button_level, [7:1] unused
  input  wire logic [bsrp_pkg::IN_TDATA_W-1:0] in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [1:0] band_index, [2] select_20m, [3] select_15m, [4] relay12_set,
  // [5] relay12_reset, [6] relay34_set, [7] relay34_reset, [8] cal_line,
  // [15:9] zero
  output logic [bsrp_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bsrp_pkg::PULSE_W-1:0]    cfg_wr_data
);

  logic              tick_acc;
  bsrp_pkg::result_t core_res;
  bsrp_pkg::result_t buf_res;

  assign tick_acc = in_tvalid & in_tready;

  // Tick state lives in the core and advances only on an accepted item
  bsrp_core #(
    .RELEASE_RUN (RELEASE_RUN)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick_acc     (tick_acc),
    .button_level (in_tdata[0]),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result       (core_res)
  );

  bsrp_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_data   (core_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (buf_res)
  );

  assign out_tdata = {7'b0,
                      buf_res.cal_line,
                      buf_res.relay34_reset,
                      buf_res.relay34_set,
                      buf_res.relay12_reset,
                      buf_res.relay12_set,
                      buf_res.select_15m,
                      buf_res.select_20m,
                      buf_res.band_index};

endmodule

`default_nettype wire
